### rtl/core/arcqt_pkg.sv
// Shared types, constants and the MAC microprogram of the arcball tracker.
package arcqt_pkg;

	localparam logic signed [31:0] ONE_Q29 = 32'sh2000_0000;
	localparam logic signed [17:0] ONE_Q16 = 18'sh1_0000;

	localparam logic [5:0] N_XY_IN  = 6'd17;
	localparam logic [5:0] N_Z_DIV  = 6'd33;
	localparam logic [5:0] N_Z_SQRT = 6'd17;
	localparam logic [5:0] N_S_SQRT = 6'd29;
	localparam logic [5:0] N_XY_OUT = 6'd18;

	localparam logic [4:0] K_STEP = 5'd3;
	localparam logic [4:0] K_PROD = 5'd12;

	typedef enum logic [3:0] {
		SRC_DX, SRC_DY, SRC_R,
		SRC_A0, SRC_A1, SRC_A2,
		SRC_P0, SRC_P1, SRC_P2,
		SRC_W1, SRC_X1, SRC_Y1, SRC_Z1,
		SRC_O0, SRC_O1, SRC_O2
	} src_t;

	typedef enum logic [3:0] {
		DST_D2, DST_R2,
		DST_W1, DST_X1, DST_Y1, DST_Z1,
		DST_N0, DST_N1, DST_N2, DST_N3
	} dst_t;

	typedef struct packed {
		logic first;
		logic neg;
		logic sh29;
		logic last;
		dst_t dst;
	} mac_ctl_t;

	typedef struct packed {
		src_t     sa;
		logic     use_o3;
		src_t     sb;
		logic     brk;
		mac_ctl_t ctl;
	} uop_t;

	typedef struct packed {
		logic       start;
		logic       is_sqrt;
		logic [5:0] iters;
	} ds_req_t;

	function automatic uop_t mk(input src_t a, input src_t b, input logic o3,
			input logic first, input logic neg, input logic last,
			input logic brk, input logic sh29, input dst_t d);
		uop_t u;
		u.sa = a;
		u.sb = b;
		u.use_o3 = o3;
		u.brk = brk;
		u.ctl.first = first;
		u.ctl.neg = neg;
		u.ctl.sh29 = sh29;
		u.ctl.last = last;
		u.ctl.dst = d;
		return u;
	endfunction

	// b operand O3 is flagged separately (source code space is full)
	function automatic uop_t mac_uop(input logic [4:0] k);
		uop_t u;
		unique case (k)
			5'd0:  u = mk(SRC_DX, SRC_DX, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_D2);
			5'd1:  u = mk(SRC_DY, SRC_DY, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_D2);
			5'd2:  u = mk(SRC_R,  SRC_R,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, DST_R2);
			5'd3:  u = mk(SRC_A0, SRC_P0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_W1);
			5'd4:  u = mk(SRC_A1, SRC_P1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_W1);
			5'd5:  u = mk(SRC_A2, SRC_P2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DST_W1);
			5'd6:  u = mk(SRC_A1, SRC_P2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_X1);
			5'd7:  u = mk(SRC_A2, SRC_P1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_X1);
			5'd8:  u = mk(SRC_A2, SRC_P0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Y1);
			5'd9:  u = mk(SRC_A0, SRC_P2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_Y1);
			5'd10: u = mk(SRC_A0, SRC_P1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Z1);
			5'd11: u = mk(SRC_A1, SRC_P0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, DST_Z1);
			5'd12: u = mk(SRC_W1, SRC_O0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_N0);
			5'd13: u = mk(SRC_X1, SRC_O1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_N0);
			5'd14: u = mk(SRC_Y1, SRC_O2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_N0);
			5'd15: u = mk(SRC_Z1, SRC_O0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, DST_N0);
			5'd16: u = mk(SRC_W1, SRC_O1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_N1);
			5'd17: u = mk(SRC_X1, SRC_O0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, DST_N1);
			5'd18: u = mk(SRC_Y1, SRC_O0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, DST_N1);
			5'd19: u = mk(SRC_Z1, SRC_O2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, DST_N1);
			5'd20: u = mk(SRC_W1, SRC_O2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_N2);
			5'd21: u = mk(SRC_X1, SRC_O0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_N2);
			5'd22: u = mk(SRC_Y1, SRC_O0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, DST_N2);
			5'd23: u = mk(SRC_Z1, SRC_O1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, DST_N2);
			5'd24: u = mk(SRC_W1, SRC_O0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, DST_N3);
			5'd25: u = mk(SRC_X1, SRC_O2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, DST_N3);
			5'd26: u = mk(SRC_Y1, SRC_O1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_N3);
			5'd27: u = mk(SRC_Z1, SRC_O0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, DST_N3);
			default: u = mk(SRC_DX, SRC_DX, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, DST_D2);
		endcase
		return u;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -40'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

### rtl/core/arcqt_dsu.sv
// Bit-serial restoring divider and square root, one result bit per cycle.
module arcqt_dsu
	import arcqt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ds_req_t     req,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [33:0] res
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        sqrt_q;
	logic [33:0] rem_q;
	logic [63:0] sh_q;
	logic [33:0] res_q;
	logic [31:0] den_q;
	logic [35:0] t_w;
	logic [35:0] trial_w;
	logic [35:0] diff_w;
	logic        ge_w;

	always_comb begin
		if (sqrt_q) begin
			t_w = {rem_q, sh_q[63:62]};
			trial_w = {res_q, 2'b01};
		end else begin
			t_w = {1'b0, rem_q, sh_q[63]};
			trial_w = {4'b0, den_q};
		end
		ge_w = t_w >= trial_w;
		diff_w = t_w - trial_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.is_sqrt;
			den_q <= den;
			res_q <= '0;
			if (req.is_sqrt) begin
				rem_q <= '0;
				sh_q <= num << (7'd64 - {req.iters, 1'b0});
			end else begin
				rem_q <= 34'(num >> req.iters);
				sh_q <= num << (7'd64 - {1'b0, req.iters});
			end
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[33:0] : t_w[33:0];
			res_q <= {res_q[32:0], ge_w};
			sh_q <= sqrt_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

### rtl/core/arcqt_mac.sv
// Pipelined multiply-accumulate unit with tagged writeback.
module arcqt_mac
	import arcqt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  mac_ctl_t           ctl,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic signed [39:0] acc,
	output logic               wb_valid,
	output dst_t               wb_dst
);

	logic               valid_s1;
	mac_ctl_t           ctl_s1;
	logic signed [63:0] prod_s1;
	logic signed [63:0] shr_w;
	logic signed [39:0] term_w;
	logic signed [39:0] acc_q;
	logic               wb_q;
	dst_t               dst_q;

	always_comb begin
		shr_w = prod_s1 >>> 29;
		term_w = ctl_s1.sh29 ? shr_w[39:0] : prod_s1[39:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wb_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			wb_q <= valid_s1 & ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		ctl_s1 <= ctl;
		dst_q <= ctl_s1.dst;
		if (valid_s1)
			acc_q <= (ctl_s1.first ? 40'sd0 : acc_q) + (ctl_s1.neg ? -term_w : term_w);
	end

	assign acc = acc_q;
	assign wb_valid = wb_q;
	assign wb_dst = dst_q;

endmodule

### rtl/core/arcball_quaternion_tracker.sv
// Arcball tracker top level: registers, sequencer and sphere mapping.
//
// Input stream: s_tvalid/s_tready/s_tdata/s_tuser, one pointer event per
// transfer; s_tuser[0] is 0 to start a drag and 1 to continue it.
// Output stream: m_tvalid/m_tready/m_tdata, one orientation quaternion per
// event, Q2.29 components.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// index 0 centre x, 1 centre y, 2 radius. Write only while idle.
// Each event runs the bit-serial divide and square root unit (one bit per
// cycle, three runs off the ball, four on it) plus 3 multiply-accumulate
// issues, and 25 more for a drag, on the single 32x32 multiplier.
// s_tready is high only while the sequencer waits for an event.
// A finished result sits in the output register; the next event is taken
// the cycle after the result is loaded there, and a further result waits
// in the sequencer until the receiver takes the pending one.
// Reset sets radius 256, centre 0, anchor (0,0,1), identity orientation.
module arcball_quaternion_tracker
	import arcqt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // mouse_x[11:0], mouse_y[23:12]
	input  logic [0:0]   s_tuser,   // func[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // quat_w, quat_x, quat_y, quat_z (32 bits each)
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [11:0]  cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MAC  = 6'b000010,
		ST_WAIT = 6'b000100,
		ST_DSI  = 6'b001000,
		ST_DSR  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [11:0]        cx_q;
	logic [11:0]        cy_q;
	logic [11:0]        rad_q;
	logic               func_q;
	logic signed [12:0] dx_q;
	logic signed [12:0] dy_q;
	logic [11:0]        r_q;
	logic [25:0]        d2_q;
	logic [23:0]        r2_q;
	logic [4:0]         k_q;
	logic               wcnt_q;
	logic [1:0]         j_q;
	logic [33:0]        t_q;
	logic signed [17:0] p_q [3];
	logic signed [17:0] a_q [3];
	logic signed [31:0] o_q [4];
	logic signed [31:0] s1_q [4];
	logic signed [31:0] n_q [4];
	logic [127:0]       out_q;
	logic               m_valid_q;

	logic signed [12:0] dx_w;
	logic signed [12:0] dy_w;
	logic [11:0]        adx_w;
	logic [11:0]        ady_w;
	logic               in_w;
	logic               load_out_w;
	uop_t               uop_w;
	logic signed [31:0] src_w [16];
	logic signed [31:0] op_b_w;
	ds_req_t            ds_req_w;
	logic [63:0]        ds_num_w;
	logic [31:0]        ds_den_w;
	logic               ds_done;
	logic [33:0]        ds_res;
	logic signed [39:0] acc;
	logic signed [39:0] acc_sh_w;
	logic               wb_valid;
	dst_t               wb_dst;

	function automatic logic signed [17:0] sph(input logic neg, input logic [33:0] mag);
		logic [17:0] m;
		m = mag[17:0];
		if (mag > 34'd131071)
			return neg ? 18'sh2_0000 : 18'sh1_ffff;
		return neg ? $signed(-m) : $signed(m);
	endfunction

	assign dx_w = $signed({1'b0, s_tdata[11:0]}) - $signed({1'b0, cx_q});
	assign dy_w = $signed({1'b0, s_tdata[23:12]}) - $signed({1'b0, cy_q});
	assign adx_w = dx_q[12] ? 12'(-dx_q) : dx_q[11:0];
	assign ady_w = dy_q[12] ? 12'(-dy_q) : dy_q[11:0];
	assign in_w = d2_q <= {2'b00, r2_q};
	assign load_out_w = (state_q == ST_DONE) && (!m_valid_q || m_tready);
	assign uop_w = mac_uop(k_q);
	assign acc_sh_w = acc >>> 3;

	always_comb begin
		src_w[SRC_DX] = 32'(dx_q);
		src_w[SRC_DY] = 32'(dy_q);
		src_w[SRC_R]  = {20'b0, r_q};
		src_w[SRC_A0] = 32'(a_q[0]);
		src_w[SRC_A1] = 32'(a_q[1]);
		src_w[SRC_A2] = 32'(a_q[2]);
		src_w[SRC_P0] = 32'(p_q[0]);
		src_w[SRC_P1] = 32'(p_q[1]);
		src_w[SRC_P2] = 32'(p_q[2]);
		src_w[SRC_W1] = s1_q[0];
		src_w[SRC_X1] = s1_q[1];
		src_w[SRC_Y1] = s1_q[2];
		src_w[SRC_Z1] = s1_q[3];
		src_w[SRC_O0] = o_q[0];
		src_w[SRC_O1] = o_q[1];
		src_w[SRC_O2] = o_q[2];
		op_b_w = uop_w.use_o3 ? o_q[3] : src_w[uop_w.sb];
	end

	always_comb begin
		ds_req_w.start = (state_q == ST_DSI) && (in_w || j_q != 2'd3);
		ds_req_w.is_sqrt = 1'b0;
		ds_req_w.iters = N_XY_IN;
		ds_num_w = '0;
		ds_den_w = {20'b0, r_q};
		if (in_w) begin
			unique case (j_q)
				2'd0: ds_num_w = {36'b0, adx_w, 16'b0};
				2'd1: ds_num_w = {36'b0, ady_w, 16'b0};
				2'd2: begin
					ds_num_w = {8'b0, r2_q - d2_q[23:0], 32'b0};
					ds_den_w = {8'b0, r2_q};
					ds_req_w.iters = N_Z_DIV;
				end
				2'd3: begin
					ds_num_w = {30'b0, t_q};
					ds_req_w.is_sqrt = 1'b1;
					ds_req_w.iters = N_Z_SQRT;
				end
				default: ds_num_w = '0;
			endcase
		end else begin
			ds_den_w = t_q[31:0];
			ds_req_w.iters = N_XY_OUT;
			priority case (j_q)
				2'd0: begin
					ds_num_w = {6'b0, d2_q, 32'b0};
					ds_req_w.is_sqrt = 1'b1;
					ds_req_w.iters = N_S_SQRT;
				end
				2'd1: ds_num_w = {20'b0, adx_w, 32'b0};
				default: ds_num_w = {20'b0, ady_w, 32'b0};
			endcase
		end
	end

	arcqt_dsu u_dsu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req_w),
		.num    (ds_num_w),
		.den    (ds_den_w),
		.done   (ds_done),
		.res    (ds_res)
	);

	arcqt_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (state_q == ST_MAC),
		.ctl      (uop_w.ctl),
		.op_a     (src_w[uop_w.sa]),
		.op_b     (op_b_w),
		.acc      (acc),
		.wb_valid (wb_valid),
		.wb_dst   (wb_dst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cx_q <= '0;
			cy_q <= '0;
			rad_q <= 12'd256;
			k_q <= '0;
			wcnt_q <= 1'b0;
			j_q <= '0;
			m_valid_q <= 1'b0;
			a_q[0] <= '0;
			a_q[1] <= '0;
			a_q[2] <= ONE_Q16;
			o_q[0] <= ONE_Q29;
			o_q[1] <= '0;
			o_q[2] <= '0;
			o_q[3] <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					2'd0: cx_q <= cfg_data;
					2'd1: cy_q <= cfg_data;
					2'd2: rad_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_valid_q && m_tready && !load_out_w)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						k_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					k_q <= k_q + 5'd1;
					if (uop_w.brk) begin
						wcnt_q <= 1'b0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					wcnt_q <= 1'b1;
					if (wcnt_q) begin
						if (k_q == K_STEP) begin
							j_q <= '0;
							state_q <= ST_DSI;
						end else if (k_q == K_PROD)
							state_q <= ST_MAC;
						else
							state_q <= ST_DONE;
					end
				end
				ST_DSI: begin
					if (ds_req_w.start)
						state_q <= ST_DSR;
					else
						state_q <= func_q ? ST_MAC : ST_DONE;
				end
				ST_DSR: begin
					if (ds_done) begin
						j_q <= j_q + 2'd1;
						if (j_q == 2'd3)
							state_q <= func_q ? ST_MAC : ST_DONE;
						else
							state_q <= ST_DSI;
					end
				end
				ST_DONE: begin
					if (load_out_w) begin
						m_valid_q <= 1'b1;
						a_q <= p_q;
						if (func_q)
							o_q <= n_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			func_q <= s_tuser[0];
			dx_q <= dx_w;
			dy_q <= dy_w;
			r_q <= (rad_q == 12'd0) ? 12'd1 : rad_q;
		end
		if (state_q == ST_DSR && ds_done) begin
			if (in_w) begin
				unique case (j_q)
					2'd0: p_q[0] <= sph(dx_q[12], ds_res);
					2'd1: p_q[1] <= sph(dy_q[12], ds_res);
					2'd2: t_q <= ds_res;
					2'd3: p_q[2] <= sph(1'b0, ds_res);
					default: ;
				endcase
			end else begin
				priority case (j_q)
					2'd0: begin
						t_q <= ds_res;
						p_q[2] <= '0;
					end
					2'd1: p_q[0] <= sph(dx_q[12], ds_res);
					default: p_q[1] <= sph(dy_q[12], ds_res);
				endcase
			end
		end
		if (wb_valid) begin
			unique case (wb_dst)
				DST_D2: d2_q <= acc[25:0];
				DST_R2: r2_q <= acc[23:0];
				DST_W1: s1_q[0] <= sat32(acc_sh_w);
				DST_X1: s1_q[1] <= sat32(acc_sh_w);
				DST_Y1: s1_q[2] <= sat32(acc_sh_w);
				DST_Z1: s1_q[3] <= sat32(acc_sh_w);
				DST_N0: n_q[0] <= sat32(acc);
				DST_N1: n_q[1] <= sat32(acc);
				DST_N2: n_q[2] <= sat32(acc);
				DST_N3: n_q[3] <= sat32(acc);
				default: ;
			endcase
		end
		if (load_out_w) begin
			if (func_q)
				out_q <= {n_q[3], n_q[2], n_q[1], n_q[0]};
			else
				out_q <= {o_q[3], o_q[2], o_q[1], o_q[0]};
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_valid_q;
	assign m_tdata = out_q;
	assign cfg_ready = 1'b1;

endmodule
